// ===== rtl/ddoi_pkg.sv =====
// shared constants, types and tables of the odometry integrator
`timescale 1ns / 1ps
`default_nettype none
package ddoi_pkg;

   // field widths
   localparam int VEL_W  = 24;
   localparam int POS_W  = 32;
   localparam int HEAD_W = 16;
   localparam int TS_W   = 16;
   localparam int SUM_W  = VEL_W + 1;

   // register reset
   localparam logic [TS_W-1:0] TS_RESET = 16'd6554;

   // cordic
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;
   localparam int ATAN_IDX_W       = 5;
   localparam int CORDIC_W         = 34;
   localparam int TRIG_W           = 18;
   localparam int QUARTER_TURN     = 16384;
   localparam int HALF_TURN        = 32768;
   localparam int CORDIC_GAIN_Q30  = 652032874;

   // shared multiplier
   localparam int MUL_A_W = 41;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int RAD_TO_BAM_Q8 = 2670177;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } ddoi_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_Q,
      ST_TRIG,
      ST_MUL_S,
      ST_MUL_H,
      ST_FINISH
   } ddoi_state_type;

   typedef enum logic [2:0] {
      MUL_LIN_TS,
      MUL_ANG_TS,
      MUL_P_COS,
      MUL_P_SIN,
      MUL_Q_K
   } ddoi_mul_sel_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } ddoi_trig_type;

   // arctangent of 2^-i in units of 2^-32 circle
   function automatic logic signed [CORDIC_W-1:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [CORDIC_W-1:0] val;
      case (idx)
         5'd0:    val = 34'sd536870912;
         5'd1:    val = 34'sd316933406;
         5'd2:    val = 34'sd167458907;
         5'd3:    val = 34'sd85004756;
         5'd4:    val = 34'sd42667331;
         5'd5:    val = 34'sd21354465;
         5'd6:    val = 34'sd10679838;
         5'd7:    val = 34'sd5340245;
         5'd8:    val = 34'sd2670163;
         5'd9:    val = 34'sd1335087;
         5'd10:   val = 34'sd667544;
         5'd11:   val = 34'sd333772;
         5'd12:   val = 34'sd166886;
         5'd13:   val = 34'sd83443;
         5'd14:   val = 34'sd41722;
         5'd15:   val = 34'sd20861;
         5'd16:   val = 34'sd10430;
         5'd17:   val = 34'sd5215;
         5'd18:   val = 34'sd2608;
         5'd19:   val = 34'sd1304;
         5'd20:   val = 34'sd652;
         5'd21:   val = 34'sd326;
         5'd22:   val = 34'sd163;
         5'd23:   val = 34'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

   // clamp a widened position sum to the signed position range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      logic signed [POS_W-1:0] res;
      if (v[POS_W+1:POS_W-1] == 3'b000 || v[POS_W+1:POS_W-1] == 3'b111) begin
         res = v[POS_W-1:0];
      end else if (v[POS_W+1]) begin
         res = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(POS_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ddoi_if.sv =====
// item channels of the odometry integrator: request, response and register write
`timescale 1ns / 1ps
`default_nettype none
interface ddoi_req_if;
   import ddoi_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic signed [VEL_W-1:0]  linear_velocity;
   logic signed [VEL_W-1:0]  angular_velocity;
   logic signed [POS_W-1:0]  load_x;
   logic signed [POS_W-1:0]  load_y;
   logic        [HEAD_W-1:0] load_heading;
   modport source (output valid, operation, linear_velocity, angular_velocity,
                   load_x, load_y, load_heading, input ready);
   modport sink   (input valid, operation, linear_velocity, angular_velocity,
                   load_x, load_y, load_heading, output ready);
endinterface

interface ddoi_rsp_if;
   import ddoi_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic        [HEAD_W-1:0] heading;
   logic signed [VEL_W-1:0]  speed_out;
   logic signed [VEL_W-1:0]  turn_rate_out;
   modport source (output valid, pos_x, pos_y, heading, speed_out, turn_rate_out,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, heading, speed_out, turn_rate_out,
                   output ready);
endinterface

interface ddoi_csr_if;
   import ddoi_pkg::*;
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] time_step;
   modport source (output valid, time_step, input ready);
   modport sink   (input valid, time_step, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddoi_cordic.sv =====
// iterative rotation-mode cordic giving cosine and sine of a binary angle
`timescale 1ns / 1ps
`default_nettype none
module ddoi_cordic #(
   parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ddoi_pkg::HEAD_W-1:0] angle,
   output logic                             done,
   output ddoi_pkg::ddoi_trig_type          trig
);
   import ddoi_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   logic                       busy_ff;
   logic                       done_ff;
   logic                       fold_ff;
   logic [STEP_W-1:0]          iter_ff;
   logic signed [CORDIC_W-1:0] x_ff;
   logic signed [CORDIC_W-1:0] y_ff;
   logic signed [CORDIC_W-1:0] z_ff;

   logic signed [HEAD_W-1:0]   ang_s;
   logic signed [HEAD_W:0]     ang_fold;
   logic                       fold_in;
   logic signed [CORDIC_W-1:0] x_shift;
   logic signed [CORDIC_W-1:0] y_shift;
   logic signed [CORDIC_W-1:0] atan_val;
   logic signed [CORDIC_W-1:0] x_round;
   logic signed [CORDIC_W-1:0] y_round;

   // fold the angle into the right half plane
   always_comb begin
      ang_s = $signed(angle);
      if (ang_s > QUARTER_TURN) begin
         ang_fold = (HEAD_W+1)'(ang_s) - (HEAD_W+1)'(HALF_TURN);
         fold_in  = 1'b1;
      end else if (ang_s < -QUARTER_TURN) begin
         ang_fold = (HEAD_W+1)'(ang_s) + (HEAD_W+1)'(HALF_TURN);
         fold_in  = 1'b1;
      end else begin
         ang_fold = (HEAD_W+1)'(ang_s);
         fold_in  = 1'b0;
      end
   end

   // one micro-rotation per cycle
   assign x_shift  = x_ff >>> iter_ff;
   assign y_shift  = y_ff >>> iter_ff;
   assign atan_val = atan_bam(ATAN_IDX_W'(iter_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && iter_ff == STEP_W'(CORDIC_STEPS - 1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         iter_ff <= '0;
         fold_ff <= fold_in;
         x_ff    <= CORDIC_W'(CORDIC_GAIN_Q30);
         y_ff    <= '0;
         z_ff    <= CORDIC_W'(ang_fold) <<< HEAD_W;
      end else if (busy_ff) begin
         iter_ff <= iter_ff + 1'b1;
         if (!z_ff[CORDIC_W-1]) begin
            x_ff <= x_ff - y_shift;
            y_ff <= y_ff + x_shift;
            z_ff <= z_ff - atan_val;
         end else begin
            x_ff <= x_ff + y_shift;
            y_ff <= y_ff - x_shift;
            z_ff <= z_ff + atan_val;
         end
      end
   end

   // round to q16 and undo the fold
   assign x_round = (x_ff + CORDIC_W'(8192)) >>> 14;
   assign y_round = (y_ff + CORDIC_W'(8192)) >>> 14;

   always_comb begin
      if (fold_ff) begin
         trig.cos_val = TRIG_W'(-x_round);
         trig.sin_val = TRIG_W'(-y_round);
      end else begin
         trig.cos_val = TRIG_W'(x_round);
         trig.sin_val = TRIG_W'(y_round);
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/ddoi_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module ddoi_mul (
   input  wire logic                                clock,
   input  wire logic signed [ddoi_pkg::MUL_A_W-1:0] op_a,
   input  wire logic signed [ddoi_pkg::MUL_B_W-1:0] op_b,
   output logic signed [ddoi_pkg::PROD_W-1:0]       prod
);
   import ddoi_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/diff_drive_odometry_integrator.sv =====
// top level: sequencer and pose datapath of the odometry integrator
`timescale 1ns / 1ps
`default_nettype none
// Dead-reckoning pose integrator for a differential-drive base. A tick item
// averages its velocity command with the previous one and moves x, y along
// the old heading (q16.16 metres, saturating) and the heading (binary angle,
// wrapping) by time_step times that mean. A load item sets the pose directly.
// One item is handled at a time: a tick waits on the cordic, which iterates
// once per cycle, with the products for distance, both pose deltas and the
// heading change sharing one registered multiplier; a load goes straight to
// the finish state. The result sits in an
// output register, so the next item is accepted while it waits to be taken.
// time_step is written over the csr channel, which is always ready.
module diff_drive_odometry_integrator #(
   parameter int CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ddoi_req_if.sink   req_chan,
   ddoi_rsp_if.source rsp_chan,
   ddoi_csr_if.sink   csr_chan
);
   import ddoi_pkg::*;

   ddoi_state_type state_ff, state_in;

   logic [TS_W-1:0]           ts_ff;
   logic signed [POS_W-1:0]   cur_x_ff;
   logic signed [POS_W-1:0]   cur_y_ff;
   logic [HEAD_W-1:0]         cur_h_ff;
   logic signed [VEL_W-1:0]   prev_lin_ff;
   logic signed [VEL_W-1:0]   prev_ang_ff;
   ddoi_op_type               op_ff;
   logic signed [VEL_W-1:0]   new_lin_ff;
   logic signed [VEL_W-1:0]   new_ang_ff;
   logic signed [SUM_W-1:0]   sum_lin_ff;
   logic signed [SUM_W-1:0]   sum_ang_ff;
   logic signed [MUL_A_W-1:0] p_ff;
   logic signed [MUL_A_W-1:0] q_ff;
   logic signed [PROD_W-1:0]  px_ff;
   logic signed [PROD_W-1:0]  py_ff;
   logic                      rsp_valid_ff;
   logic signed [POS_W-1:0]   rsp_x_ff;
   logic signed [POS_W-1:0]   rsp_y_ff;
   logic [HEAD_W-1:0]         rsp_h_ff;
   logic signed [VEL_W-1:0]   rsp_lin_ff;
   logic signed [VEL_W-1:0]   rsp_ang_ff;

   logic                      req_take;
   logic                      fin_go;
   logic                      cordic_start;
   logic                      cordic_done;
   ddoi_trig_type             trig;
   ddoi_mul_sel_type          mul_sel;
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  prod;

   logic signed [PROD_W-1:0]  dx_full;
   logic signed [PROD_W-1:0]  dy_full;
   logic signed [PROD_W-1:0]  dh_full;
   logic signed [POS_W+1:0]   sum_x;
   logic signed [POS_W+1:0]   sum_y;
   logic signed [POS_W-1:0]   new_x;
   logic signed [POS_W-1:0]   new_y;
   logic [HEAD_W-1:0]         new_h;

   // handshakes
   assign req_take       = req_chan.valid && req_chan.ready;
   assign fin_go         = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_chan.operation == OP_LOAD) ? ST_FINISH : ST_MUL_P;
            end
         end
         ST_MUL_P:  state_in = ST_MUL_Q;
         ST_MUL_Q:  state_in = ST_TRIG;
         ST_TRIG: begin
            if (cordic_done) begin
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S:  state_in = ST_MUL_H;
         ST_MUL_H:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      cordic_start   = 1'b0;
      mul_sel        = MUL_LIN_TS;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            cordic_start   = req_chan.valid && (req_chan.operation == OP_TICK);
         end
         ST_MUL_P:  mul_sel = MUL_LIN_TS;
         ST_MUL_Q:  mul_sel = MUL_ANG_TS;
         ST_TRIG:   mul_sel = cordic_done ? MUL_P_COS : MUL_ANG_TS;
         ST_MUL_S:  mul_sel = MUL_P_SIN;
         ST_MUL_H:  mul_sel = MUL_Q_K;
         ST_FINISH: mul_sel = MUL_Q_K;
         default:   mul_sel = MUL_LIN_TS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (mul_sel)
         MUL_LIN_TS: begin
            op_a = MUL_A_W'(sum_lin_ff);
            op_b = $signed(MUL_B_W'(ts_ff));
         end
         MUL_ANG_TS: begin
            op_a = MUL_A_W'(sum_ang_ff);
            op_b = $signed(MUL_B_W'(ts_ff));
         end
         MUL_P_COS: begin
            op_a = p_ff;
            op_b = MUL_B_W'(trig.cos_val);
         end
         MUL_P_SIN: begin
            op_a = p_ff;
            op_b = MUL_B_W'(trig.sin_val);
         end
         MUL_Q_K: begin
            op_a = q_ff;
            op_b = MUL_B_W'(RAD_TO_BAM_Q8);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   ddoi_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   ddoi_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cur_h_ff),
      .done  (cordic_done),
      .trig  (trig)
   );

   // time step register
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= TS_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         ts_ff <= csr_chan.time_step;
      end
   end

   // item capture and product capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= ddoi_op_type'(req_chan.operation);
         new_lin_ff <= req_chan.linear_velocity;
         new_ang_ff <= req_chan.angular_velocity;
         sum_lin_ff <= SUM_W'(req_chan.linear_velocity) + SUM_W'(prev_lin_ff);
         sum_ang_ff <= SUM_W'(req_chan.angular_velocity) + SUM_W'(prev_ang_ff);
      end
      if (state_ff == ST_MUL_Q) begin
         p_ff <= MUL_A_W'(prod);
      end
      if (state_ff == ST_TRIG) begin
         q_ff <= MUL_A_W'(prod);
      end
      if (state_ff == ST_MUL_S) begin
         px_ff <= prod;
      end
      if (state_ff == ST_MUL_H) begin
         py_ff <= prod;
      end
   end

   // pose update with rounding, saturation of x and y and wrapping of the heading
   assign dx_full = (px_ff + (PROD_W'(1) <<< 32)) >>> 33;
   assign dy_full = (py_ff + (PROD_W'(1) <<< 32)) >>> 33;
   assign dh_full = (prod + (PROD_W'(1) <<< 40)) >>> 41;
   assign sum_x   = (POS_W+2)'(cur_x_ff) + (POS_W+2)'(dx_full);
   assign sum_y   = (POS_W+2)'(cur_y_ff) + (POS_W+2)'(dy_full);
   assign new_x   = sat_pos(sum_x);
   assign new_y   = sat_pos(sum_y);
   assign new_h   = cur_h_ff + dh_full[HEAD_W-1:0];

   // pose and previous command state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         cur_h_ff    <= '0;
         prev_lin_ff <= '0;
         prev_ang_ff <= '0;
      end else if (req_take && req_chan.operation == OP_LOAD) begin
         cur_x_ff <= req_chan.load_x;
         cur_y_ff <= req_chan.load_y;
         cur_h_ff <= req_chan.load_heading;
      end else if (fin_go && op_ff == OP_TICK) begin
         cur_x_ff    <= new_x;
         cur_y_ff    <= new_y;
         cur_h_ff    <= new_h;
         prev_lin_ff <= new_lin_ff;
         prev_ang_ff <= new_ang_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         if (op_ff == OP_TICK) begin
            rsp_x_ff   <= new_x;
            rsp_y_ff   <= new_y;
            rsp_h_ff   <= new_h;
            rsp_lin_ff <= new_lin_ff;
            rsp_ang_ff <= new_ang_ff;
         end else begin
            rsp_x_ff   <= cur_x_ff;
            rsp_y_ff   <= cur_y_ff;
            rsp_h_ff   <= cur_h_ff;
            rsp_lin_ff <= prev_lin_ff;
            rsp_ang_ff <= prev_ang_ff;
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pos_x         = rsp_x_ff;
   assign rsp_chan.pos_y         = rsp_y_ff;
   assign rsp_chan.heading       = rsp_h_ff;
   assign rsp_chan.speed_out     = rsp_lin_ff;
   assign rsp_chan.turn_rate_out = rsp_ang_ff;

endmodule
`default_nettype wire

// ===== rtl/ddoi_checker.sv =====
// port-level checks of the odometry integrator and their binding
`timescale 1ns / 1ps
`default_nettype none
module ddoi_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               req_operation,
   input wire logic signed [ddoi_pkg::POS_W-1:0]  req_load_x,
   input wire logic        [ddoi_pkg::HEAD_W-1:0] req_load_heading,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [ddoi_pkg::POS_W-1:0]  rsp_pos_x,
   input wire logic        [ddoi_pkg::HEAD_W-1:0] rsp_heading
);
   import ddoi_pkg::*;

   // a waiting item stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // a waiting item keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pos_x) && $stable(rsp_heading))
      else $error("response payload changed while stalled");

   // one item in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // no result appears in the cycle right after an accept
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a load with a free output slot passes the finish state and shows the loaded pose in the output register
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_LOAD && !rsp_valid |=> ##1
         (rsp_valid && rsp_pos_x == $past(req_load_x, 2)
                    && rsp_heading == $past(req_load_heading, 2)))
      else $error("load result wrong or late");

endmodule

bind diff_drive_odometry_integrator ddoi_checker u_ddoi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_operation    (req_chan.operation),
   .req_load_x       (req_chan.load_x),
   .req_load_heading (req_chan.load_heading),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pos_x        (rsp_chan.pos_x),
   .rsp_heading      (rsp_chan.heading)
);
`default_nettype wire

// ===== sim/diff_drive_odometry_integrator_tb.sv =====
// self-checking testbench of the odometry integrator: directed and random pose ticks and loads against a predictor
`timescale 1ns / 1ps
module diff_drive_odometry_integrator_tb;
   import ddoi_pkg::*;

   localparam int STEPS      = CORDIC_STEPS_DEF;
   localparam int RST_CYCLES = 7;
   localparam int SETTLE     = STEPS + 12;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_LEN  = 258;
   localparam int MAX_PRINTS = 40;

   localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;
   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

   typedef struct {
      ddoi_op_type              op;
      logic signed [VEL_W-1:0]  lin;
      logic signed [VEL_W-1:0]  ang;
      logic signed [POS_W-1:0]  lx;
      logic signed [POS_W-1:0]  ly;
      logic        [HEAD_W-1:0] lh;
   } odo_cmd_type;

   typedef struct {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic        [HEAD_W-1:0] h;
      logic signed [VEL_W-1:0]  v;
      logic signed [VEL_W-1:0]  w;
   } pose_type;

   logic clock;
   logic reset;

   ddoi_req_if req ();
   ddoi_rsp_if rsp ();
   ddoi_csr_if csr ();

   diff_drive_odometry_integrator #(
      .CORDIC_STEPS(STEPS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // arctangent of 2^-i in units of 2^-32 turn
   longint atan_turn [ATAN_ENTRIES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   // predicted pose state and integration period
   logic signed [POS_W-1:0]  st_x;
   logic signed [POS_W-1:0]  st_y;
   logic        [HEAD_W-1:0] st_head;
   logic signed [VEL_W-1:0]  st_lin;
   logic signed [VEL_W-1:0]  st_ang;
   logic        [TS_W-1:0]   st_ts;

   odo_cmd_type cmd_queue [$];
   pose_type    pose_queue [$];
   odo_cmd_type on_bus;

   int  items_sent;
   int  results_seen;
   int  errors;
   int  idle_cycles;
   int  gap_cnt;
   int  stall_cnt;
   bit  calm;

   task automatic flag_error(input string msg);
      if (errors < MAX_PRINTS) begin
         $display("%0t ns: mismatch: %s", $realtime, msg);
      end
      errors++;
   endtask

   // cosine and sine of a binary angle, q16, by a folded cordic
   function automatic void heading_trig(input logic [HEAD_W-1:0] hd, output longint c,
                                        output longint s);
      longint a, x, y, z, xs, ys;
      bit     flip;
      a    = longint'($signed(hd));
      flip = 1'b0;
      if (a > QUARTER_TURN) begin
         a    = a - HALF_TURN;
         flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
         a    = a + HALF_TURN;
         flip = 1'b1;
      end
      x = CORDIC_GAIN_Q30;
      y = 0;
      z = a * 65536;
      for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_turn[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_turn[i];
         end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > longint'(POS_MAX)) begin
         return POS_MAX;
      end else if (v < longint'(POS_MIN)) begin
         return POS_MIN;
      end
      return v[POS_W-1:0];
   endfunction

   // apply one item to the predicted pose and return the expected result
   function automatic pose_type advance_pose(input odo_cmd_type cmd);
      pose_type r;
      longint   p, q, c, s, dx, dy, dh;
      if (cmd.op == OP_LOAD) begin
         st_x    = cmd.lx;
         st_y    = cmd.ly;
         st_head = cmd.lh;
      end else begin
         p = (longint'(cmd.lin) + longint'(st_lin)) * longint'(st_ts);
         q = (longint'(cmd.ang) + longint'(st_ang)) * longint'(st_ts);
         heading_trig(st_head, c, s);
         dx = (p * c + 64'sh1_0000_0000) >>> 33;
         dy = (p * s + 64'sh1_0000_0000) >>> 33;
         dh = (q * RAD_TO_BAM_Q8 + 64'sh100_0000_0000) >>> 41;
         st_x    = clamp_pos(longint'(st_x) + dx);
         st_y    = clamp_pos(longint'(st_y) + dy);
         st_head = st_head + dh[HEAD_W-1:0];
         st_lin  = cmd.lin;
         st_ang  = cmd.ang;
      end
      r.x = st_x;
      r.y = st_y;
      r.h = st_head;
      r.v = st_lin;
      r.w = st_ang;
      return r;
   endfunction

   task automatic push_tick(input logic signed [VEL_W-1:0] lin,
                            input logic signed [VEL_W-1:0] ang);
      odo_cmd_type cmd;
      cmd.op  = OP_TICK;
      cmd.lin = lin;
      cmd.ang = ang;
      cmd.lx  = $urandom;
      cmd.ly  = $urandom;
      cmd.lh  = HEAD_W'($urandom);
      cmd_queue.push_back(cmd);
      items_sent++;
   endtask

   task automatic push_load(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                            input logic [HEAD_W-1:0] h);
      odo_cmd_type cmd;
      cmd.op  = OP_LOAD;
      cmd.lin = VEL_W'($urandom);
      cmd.ang = VEL_W'($urandom);
      cmd.lx  = x;
      cmd.ly  = y;
      cmd.lh  = h;
      cmd_queue.push_back(cmd);
      items_sent++;
   endtask

   function automatic logic signed [VEL_W-1:0] pick_velocity();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0, 1, 2: return r[VEL_W-1:0];
         3: begin
            case (r[1:0])
               2'd0: return VEL_MAX;
               2'd1: return VEL_MIN;
               2'd2: return '0;
               default: return '1;
            endcase
         end
         default: return VEL_W'($signed(r[17:0]));
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] pick_position();
      case ($urandom_range(0, 4))
         0: return POS_MAX - POS_W'($urandom_range(0, 1 << 22));
         1: return POS_MIN + POS_W'($urandom_range(0, 1 << 22));
         2: return POS_W'($signed(24'($urandom)));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [HEAD_W-1:0] pick_heading();
      logic [HEAD_W-1:0] h;
      if ($urandom_range(0, 2) == 0) begin
         h = HEAD_W'($urandom_range(0, 3) * QUARTER_TURN);
         return h + HEAD_W'($urandom_range(0, 2)) - 1'b1;
      end
      return HEAD_W'($urandom);
   endfunction

   // mostly ticks whose command components each change at random, now and then a pose load
   task automatic push_random_phase(input int count);
      logic signed [VEL_W-1:0] lin, ang;
      int n;
      lin = pick_velocity();
      ang = pick_velocity();
      n   = 0;
      while (n < count) begin
         if ($urandom_range(0, 7) == 0) begin
            push_load(pick_position(), pick_position(), pick_heading());
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               lin = pick_velocity();
            end
            if ($urandom_range(0, 1) == 0) begin
               ang = pick_velocity();
            end
            push_tick(lin, ang);
         end
         n++;
      end
   endtask

   task automatic wait_drained();
      while (results_seen != items_sent) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_time_step(input logic [TS_W-1:0] value);
      csr.valid     <= 1'b1;
      csr.time_step <= value;
      do begin
         @(posedge clock);
      end while (!csr.ready);
      csr.valid <= 1'b0;
      st_ts = value;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sequence of phases
   initial begin
      reset            = 1'b1;
      calm             = 1'b0;
      req.valid        = 1'b0;
      req.operation    = OP_TICK;
      req.linear_velocity  = '0;
      req.angular_velocity = '0;
      req.load_x       = '0;
      req.load_y       = '0;
      req.load_heading = '0;
      rsp.ready        = 1'b0;
      csr.valid        = 1'b0;
      csr.time_step    = '0;
      items_sent       = 0;
      st_x             = '0;
      st_y             = '0;
      st_head          = '0;
      st_lin           = '0;
      st_ang           = '0;
      st_ts            = TS_RESET;
      repeat (RST_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: velocity extremes, saturation on both sides, fold boundaries
      push_tick('0, '0);
      push_tick(VEL_MAX, VEL_MAX);
      push_tick(VEL_MIN, VEL_MIN);
      push_tick(VEL_MAX, VEL_MIN);
      push_load(POS_MAX, POS_MIN, 16'hFFFF);
      push_tick(VEL_MAX, '0);
      push_load(POS_MIN, POS_MAX, 16'h8000);
      push_tick(VEL_MAX, '0);
      push_load('0, '0, 16'h4000);
      push_tick(VEL_MAX, 24'sh010000);
      push_load('0, '0, 16'h4001);
      push_tick(VEL_MIN, '0);
      push_load('0, '0, 16'hBFFF);
      push_tick(VEL_MAX, '0);
      push_load('0, '0, 16'hC000);
      push_tick(24'sh010000, VEL_MAX);
      push_load('0, '0, 16'h7FFF);
      push_tick(VEL_MAX, VEL_MAX);
      push_tick(VEL_MAX, VEL_MAX);
      wait_drained();

      // zero period: pose must stand still
      write_time_step('0);
      push_tick(VEL_MAX, VEL_MAX);
      push_load(32'sh0001_8000, -32'sh0002_0000, 16'h2000);
      push_tick(VEL_MIN, VEL_MIN);
      wait_drained();

      // random phases over several periods
      write_time_step(16'hFFFF);
      push_random_phase(PHASE_LEN);
      wait_drained();
      write_time_step(16'd1);
      push_random_phase(PHASE_LEN);
      wait_drained();
      write_time_step(TS_W'($urandom_range(1, 65535)));
      push_random_phase(PHASE_LEN);
      wait_drained();
      write_time_step(16'h8000);
      push_random_phase(PHASE_LEN);
      wait_drained();
      write_time_step(TS_W'($urandom_range(1, 65535)));
      push_random_phase(PHASE_LEN);
      wait_drained();

      // last stretch at full rate on both sides
      write_time_step(TS_RESET);
      calm = 1'b1;
      push_random_phase(PHASE_LEN);
      wait_drained();

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // request driver with random idle bursts
   always @(posedge clock) begin : req_drive
      logic next_valid;
      if (reset) begin
         req.valid <= 1'b0;
         gap_cnt   <= 0;
      end else if (!(req.valid && !req.ready)) begin
         if (req.valid && req.ready) begin
            pose_queue.push_back(advance_pose(on_bus));
         end
         next_valid = 1'b0;
         if (gap_cnt > 0) begin
            gap_cnt <= gap_cnt - 1;
         end else if (cmd_queue.size() != 0) begin
            on_bus     = cmd_queue.pop_front();
            next_valid = 1'b1;
            req.operation        <= on_bus.op;
            req.linear_velocity  <= on_bus.lin;
            req.angular_velocity <= on_bus.ang;
            req.load_x           <= on_bus.lx;
            req.load_y           <= on_bus.ly;
            req.load_heading     <= on_bus.lh;
            if (!calm && $urandom_range(0, 3) == 0) begin
               gap_cnt <= $urandom_range(1, 11);
            end
         end
         req.valid <= next_valid;
      end
   end

   // result monitor with random stall bursts
   always @(posedge clock) begin : rsp_check
      pose_type want;
      if (reset) begin
         rsp.ready    <= 1'b0;
         stall_cnt    <= 0;
         results_seen = 0;
         errors       = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pose_queue.size() == 0) begin
               flag_error("result with no item outstanding");
            end else begin
               want = pose_queue.pop_front();
               if (rsp.pos_x !== want.x)
                  flag_error($sformatf("pos_x got %0d want %0d", rsp.pos_x, want.x));
               if (rsp.pos_y !== want.y)
                  flag_error($sformatf("pos_y got %0d want %0d", rsp.pos_y, want.y));
               if (rsp.heading !== want.h)
                  flag_error($sformatf("heading got %0d want %0d", rsp.heading, want.h));
               if (rsp.speed_out !== want.v)
                  flag_error($sformatf("speed_out got %0d want %0d", rsp.speed_out, want.v));
               if (rsp.turn_rate_out !== want.w)
                  flag_error($sformatf("turn_rate_out got %0d want %0d",
                                       rsp.turn_rate_out, want.w));
               results_seen++;
            end
         end
         if (stall_cnt > 0) begin
            rsp.ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
         end else begin
            rsp.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) begin
               stall_cnt <= $urandom_range(1, 11);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
